### hw/rtl/utc_to_local_time_with_sync_check_macros.svh
// ----------------------------------------------------------------------------
// UTC to local time: assertion macros
// Concurrent assertion shorthands shared by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef UTC_TO_LOCAL_TIME_WITH_SYNC_CHECK_MACROS_SVH
`define UTC_TO_LOCAL_TIME_WITH_SYNC_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTCL_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UTCL_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/utcl_pkg.sv
// ----------------------------------------------------------------------------
// UTC to local time: shared package
// Constants, register indexes, date types and the month length function.
// ----------------------------------------------------------------------------
package utcl_pkg;

    localparam int MIN_PER_HOUR  = 60;
    localparam int MIN_PER_DAY   = 1440;
    localparam int SEC_PER_MIN   = 60;
    localparam int SEC_PER_HOUR  = 3600;
    localparam int SEC_PER_DAY   = 86400;
    localparam int HALF_DAY_SEC  = 43200;

    // floor(x / 60) == (x * RECIP60) >> RECIP60_SHIFT for x < 1440
    localparam int RECIP60       = 2185;
    localparam int RECIP60_SHIFT = 17;

    // y divisible by 25 <=> (y * INV25) mod 2^16 <= 65535 / 25 (25 is odd)
    localparam int INV25         = 23593;
    localparam int DIV25_LIMIT   = 65535 / 25;

    localparam int SYNC_THR_RESET = 60;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef enum logic [1:0] {
        CFG_TZ_HOURS       = 2'd0,
        CFG_TZ_MINUTES     = 2'd1,
        CFG_TZ_NEGATIVE    = 2'd2,
        CFG_SYNC_THRESHOLD = 2'd3
    } cfg_idx_t;

    // Date with the day already moved by whole days (may be -1..33).
    typedef struct packed {
        logic [15:0]        year;
        logic [3:0]         month;
        logic signed [6:0]  day;
    } date_raw_t;

    // Date after month and year rollover.
    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic       is_leap);
        logic [4:0] len;
        begin
            case (month)
                MONTH_FEB: len = is_leap ? 5'd29 : 5'd28;
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
                default:   len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

### hw/rtl/utc_to_local_time_with_sync_check.sv
// ----------------------------------------------------------------------------
// UTC to local time with sync check
// Applies the time-zone offset to a UTC timestamp, rolls day, month and year,
// and flags when the real-time clock has drifted from local time.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Signals                                   Carries
//  --------  ---  ----------------------------------------  ------------------
//  s_axis    in   s_axis_tvalid/tready/tdata[63:0]          UTC stamp + clock
//  m_axis    out  m_axis_tvalid/tready/tdata[47:0]          local stamp + sync
//  cfg       in   cfg_valid/cfg_ready/cfg_index/cfg_data    register writes
//
//  One transfer per cycle while m_axis_tready stays high; five register
//  stages (offset/day, divide by 60 + leap test, month roll,
//  second-of-day difference, fold + compare/output).
//  Valid bits travel with each stage; a stage advances when it is empty or
//  the stage after it advances, so back-pressure stops only full stages.
//  rst_n (async, active low) empties the pipeline and loads register resets:
//  offset zero, threshold 60 s. cfg_ready is always high.
//
`include "utc_to_local_time_with_sync_check_macros.svh"

module utc_to_local_time_with_sync_check (
    input  logic                clk,
    input  logic                rst_n,
    // utc_year[15:0] utc_month[19:16] utc_day[24:20] utc_hour[29:25]
    // utc_minute[35:30] utc_second[41:36] clock_hour[46:42]
    // clock_minute[52:47] clock_second[58:53], [63:59] zero
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,
    // local_year[15:0] local_month[19:16] local_day[24:20] local_hour[29:25]
    // local_minute[35:30] local_second[41:36] sync_needed[42], [47:43] zero
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [47:0]         m_axis_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  utcl_pkg::cfg_idx_t  cfg_index,
    input  logic [15:0]         cfg_data
);
    import utcl_pkg::*;

    localparam int NSTAGE = 5;

    // ---------------- configuration registers
    logic [3:0]  zone_hours_reg;
    logic [5:0]  tz_minutes_reg;
    logic        tz_negative_reg;
    logic [15:0] sync_thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_hours_reg  <= '0;
            tz_minutes_reg  <= '0;
            tz_negative_reg <= 1'b0;
            sync_thr_reg    <= 16'(SYNC_THR_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TZ_HOURS:       zone_hours_reg  <= cfg_data[3:0];
                CFG_TZ_MINUTES:     tz_minutes_reg  <= cfg_data[5:0];
                CFG_TZ_NEGATIVE:    tz_negative_reg <= cfg_data[0];
                CFG_SYNC_THRESHOLD: sync_thr_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ---------------- pipeline control
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] adv;

    // a stage may load when empty or when its contents move on
    always_comb
    begin
        adv[NSTAGE-1] = !vld_reg[NSTAGE-1] || m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = adv[0] ? s_axis_tvalid : vld_reg[0];
        for (int k = 1; k < NSTAGE; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = vld_reg[NSTAGE-1];

    // ---------------- input unpacking
    logic [15:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [4:0]  in_clk_hour;
    logic [5:0]  in_clk_minute;
    logic [5:0]  in_clk_second;

    assign in_year       = s_axis_tdata[15:0];
    assign in_month      = s_axis_tdata[19:16];
    assign in_day        = s_axis_tdata[24:20];
    assign in_hour       = s_axis_tdata[29:25];
    assign in_minute     = s_axis_tdata[35:30];
    assign in_second     = s_axis_tdata[41:36];
    assign in_clk_hour   = s_axis_tdata[46:42];
    assign in_clk_minute = s_axis_tdata[52:47];
    assign in_clk_second = s_axis_tdata[58:53];

    // ---------------- stage 1: offset, day move, clock second of day
    // Minute of day spans -963..2886, so the day moves by -1, +1 or +2.
    logic [9:0]         tz_off;
    logic [10:0]        utc_mod;
    logic signed [12:0] tot_raw;
    logic signed [12:0] tot_norm;
    logic signed [2:0]  day_adj;
    logic [16:0]        rtc_raw;

    always_comb
    begin
        tz_off  = 10'(zone_hours_reg * 10'(MIN_PER_HOUR)) + 10'(tz_minutes_reg);
        utc_mod = 11'(in_hour * 11'(MIN_PER_HOUR)) + 11'(in_minute);
        if (tz_negative_reg)
        begin
            tot_raw = $signed({2'b00, utc_mod}) - $signed({3'b000, tz_off});
        end
        else
        begin
            tot_raw = $signed({2'b00, utc_mod}) + $signed({3'b000, tz_off});
        end

        if (tot_raw < 13'sd0)
        begin
            tot_norm = tot_raw + 13'(MIN_PER_DAY);
            day_adj  = -3'sd1;
        end
        else if (tot_raw >= 13'(2 * MIN_PER_DAY))
        begin
            tot_norm = tot_raw - 13'(2 * MIN_PER_DAY);
            day_adj  = 3'sd2;
        end
        else if (tot_raw >= 13'(MIN_PER_DAY))
        begin
            tot_norm = tot_raw - 13'(MIN_PER_DAY);
            day_adj  = 3'sd1;
        end
        else
        begin
            tot_norm = tot_raw;
            day_adj  = 3'sd0;
        end

        rtc_raw = 17'(in_clk_hour * 17'(SEC_PER_HOUR))
                + 17'(in_clk_minute * 17'(SEC_PER_MIN))
                + 17'(in_clk_second);
    end

    logic [15:0]       s1_year_reg;
    logic [3:0]        s1_month_reg;
    logic signed [6:0] s1_day_reg;
    logic [10:0]       s1_tot_reg;
    logic [5:0]        s1_sec_reg;
    logic [16:0]       s1_rtc_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_year_reg  <= in_year;
            s1_month_reg <= in_month;
            s1_day_reg   <= $signed({2'b00, in_day}) + 7'(day_adj);
            s1_tot_reg   <= tot_norm[10:0];
            s1_sec_reg   <= in_second;
            s1_rtc_reg   <= rtc_raw;
        end
    end

    // ---------------- stage 2: hour of day, leap year, clock mod day
    logic [22:0] hour_prod;
    logic [31:0] yr_prod;
    logic        div25;
    logic        is_leap;
    logic [16:0] rtc_mod;

    always_comb
    begin
        hour_prod = 23'(s1_tot_reg * 23'(RECIP60));
        yr_prod   = s1_year_reg * 32'(INV25);
        div25     = (yr_prod[15:0] <= 16'(DIV25_LIMIT));
        // leap: /4 and (not /100 or /400); /400 == /16 and /25
        is_leap   = (s1_year_reg[1:0] == 2'b00) && (!div25 || s1_year_reg[3:0] == 4'h0);
        rtc_mod   = (s1_rtc_reg >= 17'(SEC_PER_DAY)) ? s1_rtc_reg - 17'(SEC_PER_DAY)
                                                      : s1_rtc_reg;
    end

    logic [15:0]       s2_year_reg;
    logic [3:0]        s2_month_reg;
    logic signed [6:0] s2_day_reg;
    logic              s2_leap_reg;
    logic [10:0]       s2_tot_reg;
    logic [4:0]        s2_hour_reg;
    logic [5:0]        s2_sec_reg;
    logic [16:0]       s2_rtc_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_year_reg  <= s1_year_reg;
            s2_month_reg <= s1_month_reg;
            s2_day_reg   <= s1_day_reg;
            s2_leap_reg  <= is_leap;
            s2_tot_reg   <= s1_tot_reg;
            s2_hour_reg  <= hour_prod[RECIP60_SHIFT+4:RECIP60_SHIFT];
            s2_sec_reg   <= s1_sec_reg;
            s2_rtc_reg   <= rtc_mod;
        end
    end

    // ---------------- stage 3: minute of hour, month/year rollover
    date_raw_t   raw_date;
    date_t       rolled_date;
    logic [10:0] min_rem;

    always_comb
    begin
        raw_date.year  = s2_year_reg;
        raw_date.month = s2_month_reg;
        raw_date.day   = s2_day_reg;
        min_rem        = s2_tot_reg - 11'(s2_hour_reg * 11'(MIN_PER_HOUR));
    end

    utcl_date_roll u_date_roll (
        .raw     (raw_date),
        .is_leap (s2_leap_reg),
        .rolled  (rolled_date)
    );

    date_t       s3_date_reg;
    logic [4:0]  s3_hour_reg;
    logic [5:0]  s3_min_reg;
    logic [5:0]  s3_sec_reg;
    logic [16:0] s3_rtc_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_date_reg <= rolled_date;
            s3_hour_reg <= s2_hour_reg;
            s3_min_reg  <= min_rem[5:0];
            s3_sec_reg  <= s2_sec_reg;
            s3_rtc_reg  <= s2_rtc_reg;
        end
    end

    // ---------------- stage 4: local second of day, absolute difference
    // Seconds up to 63 can push the local second of day past midnight.
    logic [16:0] loc_raw;
    logic [16:0] loc_mod;
    logic [16:0] sec_diff;

    always_comb
    begin
        loc_raw  = 17'(s3_hour_reg * 17'(SEC_PER_HOUR))
                 + 17'(s3_min_reg * 17'(SEC_PER_MIN))
                 + 17'(s3_sec_reg);
        loc_mod  = (loc_raw >= 17'(SEC_PER_DAY)) ? loc_raw - 17'(SEC_PER_DAY) : loc_raw;
        sec_diff = (s3_rtc_reg >= loc_mod) ? s3_rtc_reg - loc_mod : loc_mod - s3_rtc_reg;
    end

    date_t       s4_date_reg;
    logic [4:0]  s4_hour_reg;
    logic [5:0]  s4_min_reg;
    logic [5:0]  s4_sec_reg;
    logic [16:0] s4_diff_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_date_reg <= s3_date_reg;
            s4_hour_reg <= s3_hour_reg;
            s4_min_reg  <= s3_min_reg;
            s4_sec_reg  <= s3_sec_reg;
            s4_diff_reg <= sec_diff;
        end
    end

    // ---------------- stage 5: fold at half a day, threshold, output register
    logic [16:0] diff_fold;
    logic        sync_flag;

    always_comb
    begin
        diff_fold = (s4_diff_reg > 17'(HALF_DAY_SEC)) ? 17'(SEC_PER_DAY) - s4_diff_reg
                                                      : s4_diff_reg;
        sync_flag = (diff_fold >= {1'b0, sync_thr_reg});
    end

    date_t      out_date_reg;
    logic [4:0] out_hour_reg;
    logic [5:0] out_min_reg;
    logic [5:0] out_sec_reg;
    logic       out_sync_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            out_date_reg <= s4_date_reg;
            out_hour_reg <= s4_hour_reg;
            out_min_reg  <= s4_min_reg;
            out_sec_reg  <= s4_sec_reg;
            out_sync_reg <= sync_flag;
        end
    end

    assign m_axis_tdata = {5'b00000, out_sync_reg, out_sec_reg, out_min_reg, out_hour_reg,
                           out_date_reg.day, out_date_reg.month, out_date_reg.year};

    // ---------------- assertions
    `UTCL_ASSERT_IMP(a_stall_means_full, clk, rst_n, !s_axis_tready, (&vld_reg), "input stalled with an empty stage")
    `UTCL_ASSERT_NXT(a_take_loads_s1, clk, rst_n, s_axis_tvalid && s_axis_tready, vld_reg[0], "accepted transfer not in stage 1")
    `UTCL_ASSERT_IMP(a_s2_hour_range, clk, rst_n, vld_reg[1], s2_hour_reg <= 5'd23, "hour of day out of range")
    `UTCL_ASSERT_IMP(a_out_time_range, clk, rst_n, m_axis_tvalid, out_hour_reg <= 5'd23 && out_min_reg <= 6'd59, "local time out of range")
    `UTCL_ASSERT_IMP(a_out_day_nonzero, clk, rst_n, m_axis_tvalid, out_date_reg.day != 5'd0, "local day is zero")

endmodule

### hw/rtl/utcl_date_roll.sv
// ----------------------------------------------------------------------------
// UTC to local time: date rollover
// Rolls an adjusted day into the previous or next month and year.
// ----------------------------------------------------------------------------
module utcl_date_roll (
    input  utcl_pkg::date_raw_t raw,
    input  logic                is_leap,
    output utcl_pkg::date_t     rolled
);
    import utcl_pkg::*;

    logic [4:0] dim;
    logic [3:0] prev_month;
    logic [3:0] next_month;

    always_comb
    begin
        dim        = month_length(raw.month, is_leap);
        prev_month = (raw.month == MONTH_JAN) ? MONTH_DEC : raw.month - 4'd1;
        next_month = (raw.month == MONTH_DEC) ? MONTH_JAN : raw.month + 4'd1;

        rolled.year  = raw.year;
        rolled.month = raw.month;
        rolled.day   = raw.day[4:0];

        if (raw.month inside {[MONTH_JAN:MONTH_DEC]})
        begin
            if ($signed(raw.day) <= 7'sd0)
            begin
                // last day of previous month; Feb only comes from Mar, same year
                rolled.month = prev_month;
                rolled.day   = month_length(prev_month, is_leap);
                if (raw.month == MONTH_JAN)
                begin
                    rolled.year = raw.year - 16'd1;
                end
            end
            else if ($signed(raw.day) > $signed({2'b00, dim}))
            begin
                rolled.month = next_month;
                rolled.day   = 5'd1;
                if (raw.month == MONTH_DEC)
                begin
                    rolled.year = raw.year + 16'd1;
                end
            end
        end
        else
        begin
            // unknown month: keep month and year, clamp day
            if ($signed(raw.day) < 7'sd1)
            begin
                rolled.day = 5'd1;
            end
            else if ($signed(raw.day) > 7'sd31)
            begin
                rolled.day = 5'd31;
            end
        end
    end

endmodule
